FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request and result beats, register map, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLS_DEF      = 80;
	localparam int ROWS_DEF      = 25;
	localparam int START_ROW_DEF = 19;

	localparam int REQ_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int PADDR_W   = 3;

	localparam logic [REQ_W-1:0] REQ_CHAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd3;

	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  read_index;
	} req_item_t;

	typedef struct packed {
		logic [COL_OUT_W-1:0] cursor_col;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [CHAR_W-1:0]    cell_char;
		logic [CHAR_W-1:0]    cell_attr;
		logic                 scrolled;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCROLL,
		ST_FLUSH,
		ST_ATTR,
		ST_BS,
		ST_WIPE,
		ST_DONE
	} tcw_state_t;

	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_CHAR,
		MOP_ATTR,
		MOP_BS,
		MOP_ZERO,
		MOP_MOVE,
		MOP_READ
	} mem_op_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_NEXT,
		CUR_NEWLINE,
		CUR_BOTTOM,
		CUR_TAB,
		CUR_BACK,
		CUR_HOME
	} cur_op_t;

	typedef struct packed {
		logic    load_req;
		mem_op_t mem_op;
		cur_op_t cur_op;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    set_scroll;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             is_nl;
		logic             is_tab;
		logic             is_bs;
		logic             bottom;
		logic             last_cell;
		logic             tab_wraps;
		logic             cnt_last;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: request sequencer of the text console writer
// Decodes each request and steps the datapath through writes, scroll,
// clear and read, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire tcw_pkg::dp_stat_t  stat,
	output tcw_pkg::dp_cmd_t        cmd
);

	tcw_pkg::tcw_state_t state_q;
	tcw_pkg::tcw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req_stall      = 1'b1;
		cmd.load_req   = 1'b0;
		cmd.mem_op     = tcw_pkg::MOP_NONE;
		cmd.cur_op     = tcw_pkg::CUR_HOLD;
		cmd.cnt_clr    = 1'b0;
		cmd.cnt_inc    = 1'b0;
		cmd.set_scroll = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				cmd.mem_op  = tcw_pkg::MOP_ZERO;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = tcw_pkg::ST_DECODE;
				end
			end
			tcw_pkg::ST_DECODE: begin
				case (stat.req_type)
					tcw_pkg::REQ_CHAR: begin
						if (stat.is_nl || (stat.is_tab && stat.tab_wraps)) begin
							if (stat.bottom) begin
								cmd.cnt_clr    = 1'b1;
								cmd.set_scroll = 1'b1;
								state_d        = tcw_pkg::ST_SCROLL;
							end else begin
								cmd.cur_op = tcw_pkg::CUR_NEWLINE;
								state_d    = tcw_pkg::ST_ATTR;
							end
						end else if (stat.is_tab) begin
							cmd.cur_op = tcw_pkg::CUR_TAB;
							state_d    = tcw_pkg::ST_DONE;
						end else if (stat.is_bs) begin
							cmd.cur_op = tcw_pkg::CUR_BACK;
							state_d    = tcw_pkg::ST_BS;
						end else begin
							cmd.mem_op = tcw_pkg::MOP_CHAR;
							if (stat.last_cell) begin
								cmd.cnt_clr    = 1'b1;
								cmd.set_scroll = 1'b1;
								state_d        = tcw_pkg::ST_SCROLL;
							end else begin
								cmd.cur_op = tcw_pkg::CUR_NEXT;
								state_d    = tcw_pkg::ST_ATTR;
							end
						end
					end
					tcw_pkg::REQ_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						cmd.cur_op  = tcw_pkg::CUR_HOME;
						state_d     = tcw_pkg::ST_WIPE;
					end
					tcw_pkg::REQ_READ: begin
						cmd.mem_op = tcw_pkg::MOP_READ;
						state_d    = tcw_pkg::ST_DONE;
					end
					default: begin
						state_d = tcw_pkg::ST_DONE;
					end
				endcase
			end
			tcw_pkg::ST_SCROLL: begin
				cmd.mem_op  = tcw_pkg::MOP_MOVE;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = tcw_pkg::ST_FLUSH;
				end
			end
			tcw_pkg::ST_FLUSH: begin
				cmd.cur_op = tcw_pkg::CUR_BOTTOM;
				state_d    = tcw_pkg::ST_ATTR;
			end
			tcw_pkg::ST_ATTR: begin
				cmd.mem_op = tcw_pkg::MOP_ATTR;
				state_d    = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_BS: begin
				cmd.mem_op = tcw_pkg::MOP_BS;
				state_d    = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_WIPE: begin
				cmd.mem_op  = tcw_pkg::MOP_ZERO;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp: datapath of the text console writer
// Cell store with byte write enables, cursor registers, sweep counter,
// scroll copy stage and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
	parameter int COLS      = tcw_pkg::COLS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int START_ROW = tcw_pkg::START_ROW_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcw_pkg::req_item_t          req,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  text_attr,
	input  wire logic                        rsp_stall,
	input  wire tcw_pkg::dp_cmd_t            cmd,
	output tcw_pkg::dp_stat_t                stat,
	output logic                             rsp_valid,
	output tcw_pkg::rsp_item_t               rsp
);

	localparam int NCELLS     = COLS * ROWS;
	localparam int NMOVE      = NCELLS - COLS;
	localparam int AW         = $clog2(NCELLS);
	localparam int CW         = $clog2(COLS);
	localparam int RW         = $clog2(ROWS);
	localparam int START_R    = (START_ROW < ROWS) ? START_ROW : ROWS - 1;
	localparam int BOTTOM_POS = (ROWS - 1) * COLS;
	localparam int CELL_W     = 2 * tcw_pkg::CHAR_W;

	logic [CELL_W-1:0] cells_q [NCELLS];
	logic [CELL_W-1:0] rd_q;

	tcw_pkg::req_item_t req_q;
	logic [AW-1:0]      pos_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [AW-1:0]      cnt_q;
	logic               scroll_q;

	logic               mv_valid_s1;
	logic               mv_zero_s1;
	logic [AW-1:0]      mv_addr_s1;

	logic               out_valid_q;
	tcw_pkg::rsp_item_t out_q;

	logic               we;
	logic [1:0]         wbe;
	logic [AW-1:0]      waddr;
	logic [CELL_W-1:0]  wdata;
	logic               re;
	logic [AW-1:0]      raddr;

	logic [CW:0]        tab_col;
	logic               idx_ok;
	logic               rd_ok;

	assign tab_col = (CW+1)'((({1'b0, col_q} >> 3) + 1'b1) << 3);
	assign idx_ok  = 32'(req_q.read_index) < NCELLS;
	assign rd_ok   = (req_q.req_type == tcw_pkg::REQ_READ) && idx_ok;

	assign stat.req_type  = req_q.req_type;
	assign stat.is_nl     = req_q.char_code == tcw_pkg::CHAR_NL;
	assign stat.is_tab    = req_q.char_code == tcw_pkg::CHAR_TAB;
	assign stat.is_bs     = req_q.char_code == tcw_pkg::CHAR_BS;
	assign stat.bottom    = row_q == RW'(ROWS - 1);
	assign stat.last_cell = pos_q == AW'(NCELLS - 1);
	assign stat.tab_wraps = tab_col >= (CW+1)'(COLS);
	assign stat.cnt_last  = cnt_q == AW'(NCELLS - 1);
	assign stat.out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		we    = 1'b0;
		wbe   = 2'b00;
		waddr = pos_q;
		wdata = '0;
		if (mv_valid_s1) begin
			we    = 1'b1;
			wbe   = 2'b11;
			waddr = mv_addr_s1;
			wdata = mv_zero_s1 ? '0 : rd_q;
		end else begin
			case (cmd.mem_op)
				tcw_pkg::MOP_CHAR: begin
					we    = 1'b1;
					wbe   = 2'b11;
					wdata = {text_attr, req_q.char_code};
				end
				tcw_pkg::MOP_ATTR: begin
					we    = 1'b1;
					wbe   = 2'b10;
					wdata = {text_attr, tcw_pkg::CHAR_W'(0)};
				end
				tcw_pkg::MOP_BS: begin
					we  = 1'b1;
					wbe = 2'b01;
				end
				tcw_pkg::MOP_ZERO: begin
					we    = 1'b1;
					wbe   = 2'b11;
					waddr = cnt_q;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = AW'(req_q.read_index);
		case (cmd.mem_op)
			tcw_pkg::MOP_MOVE: begin
				re    = 32'(cnt_q) < NMOVE;
				raddr = AW'(32'(cnt_q) + COLS);
			end
			tcw_pkg::MOP_READ: begin
				re = idx_ok;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			if (wbe[0]) begin
				cells_q[waddr][tcw_pkg::CHAR_W-1:0] <= wdata[tcw_pkg::CHAR_W-1:0];
			end
			if (wbe[1]) begin
				cells_q[waddr][CELL_W-1:tcw_pkg::CHAR_W] <= wdata[CELL_W-1:tcw_pkg::CHAR_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= cells_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		mv_addr_s1 <= cnt_q;
		mv_zero_s1 <= 32'(cnt_q) >= NMOVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_valid_s1 <= 1'b0;
			cnt_q       <= '0;
			scroll_q    <= 1'b0;
		end else begin
			mv_valid_s1 <= cmd.mem_op == tcw_pkg::MOP_MOVE;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_req) begin
				scroll_q <= 1'b0;
			end else if (cmd.set_scroll) begin
				scroll_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= AW'(START_R * COLS);
			row_q <= RW'(START_R);
			col_q <= '0;
		end else begin
			case (cmd.cur_op)
				tcw_pkg::CUR_NEXT: begin
					pos_q <= pos_q + 1'b1;
					if (col_q == CW'(COLS - 1)) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				tcw_pkg::CUR_NEWLINE: begin
					pos_q <= pos_q - AW'(col_q) + AW'(COLS);
					row_q <= row_q + 1'b1;
					col_q <= '0;
				end
				tcw_pkg::CUR_BOTTOM: begin
					pos_q <= AW'(BOTTOM_POS);
					row_q <= RW'(ROWS - 1);
					col_q <= '0;
				end
				tcw_pkg::CUR_TAB: begin
					pos_q <= pos_q + AW'(tab_col - {1'b0, col_q});
					col_q <= CW'(tab_col);
				end
				tcw_pkg::CUR_BACK: begin
					if (pos_q != '0) begin
						pos_q <= pos_q - 1'b1;
						if (col_q == '0) begin
							col_q <= CW'(COLS - 1);
							row_q <= row_q - 1'b1;
						end else begin
							col_q <= col_q - 1'b1;
						end
					end
				end
				tcw_pkg::CUR_HOME: begin
					pos_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.cursor_col <= tcw_pkg::COL_OUT_W'(col_q);
			out_q.cursor_row <= tcw_pkg::ROW_OUT_W'(row_q);
			out_q.cell_char  <= rd_ok ? rd_q[tcw_pkg::CHAR_W-1:0] : '0;
			out_q.cell_attr  <= rd_ok ? rd_q[CELL_W-1:tcw_pkg::CHAR_W] : '0;
			out_q.scrolled   <= scroll_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// A new beat is taken only after the result of the previous one is loaded
// into the output register.
// Scroll and clear sweep the cell store through its single write port.
// After reset a clearing pass holds req_stall high;
// register writes are taken during it.
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Prints characters and control codes into a COLS x ROWS cell store with a
// linear cursor, scrolls, clears and reads cells; one result beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
	parameter int COLS      = tcw_pkg::COLS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int START_ROW = tcw_pkg::START_ROW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire tcw_pkg::req_item_t           req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output tcw_pkg::rsp_item_t                rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [tcw_pkg::CHAR_W-1:0] text_attr_q;
	logic                       reg_sel;
	tcw_pkg::dp_cmd_t           cmd;
	tcw_pkg::dp_stat_t          stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[tcw_pkg::PADDR_W-1] == tcw_pkg::REG_TEXT_ATTR;
	assign prdata  = reg_sel ? 32'(text_attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			text_attr_q <= pwdata[tcw_pkg::CHAR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcw_dp #(
		.COLS      (COLS),
		.ROWS      (ROWS),
		.START_ROW (START_ROW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.text_attr (text_attr_q),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request side open right after an accepted beat");

	a_scroll_lands_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.scrolled) |->
		(rsp.cursor_col == '0 && rsp.cursor_row == tcw_pkg::ROW_OUT_W'(ROWS - 1)))
		else $error("scroll result not at column 0 of the bottom row");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat loaded while the request side was open");
`endif

endmodule

`default_nettype wire

FILE: tb/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Sends request beats with random gaps against random result stalls. A local
// model of cell store, cursor and text attribute predicts each result beat not
// fixed by the plan. The attribute is reprogrammed over APB between bursts.
// ----------------------------------------------------------------------------

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int COLS        = COLS_DEF;
	localparam int ROWS        = ROWS_DEF;
	localparam int START_ROW   = START_ROW_DEF;
	localparam int NCELLS      = COLS * ROWS;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int PHASE_BEATS = 250;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASES      = 7;
	localparam int PLAN_ROWS   = 20;

	localparam logic [REQ_W-1:0]   REQ_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] ATTR_ADDR  = PADDR_W'(4 * int'(REG_TEXT_ATTR));

	typedef struct packed {
		logic [REQ_W-1:0]     req;
		logic [CHAR_W-1:0]    ch;
		logic [IDX_W-1:0]     idx;
		logic [7:0]           reps;
		logic                 fixed;
		logic [COL_OUT_W-1:0] col;
		logic [ROW_OUT_W-1:0] row;
		logic [CHAR_W-1:0]    cc;
		logic [CHAR_W-1:0]    ca;
		logic                 sc;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	req_item_t          req;
	logic               rsp_valid;
	logic               rsp_stall;
	rsp_item_t          rsp;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	logic [15:0] screen [NCELLS];
	int unsigned cursor_lin;
	logic [7:0]  attr_reg;
	rsp_item_t   pending [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int          hold_request = 0;
	plan_row_t   plan [PLAN_ROWS];

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS),
		.START_ROW(START_ROW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic line_feed();
		int unsigned row;
		logic rolled;
		row = cursor_lin / COLS;
		rolled = 1'b0;
		if (row >= ROWS - 1) begin
			for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
			for (int i = NCELLS - COLS; i < NCELLS; i++) screen[i] = '0;
			row = ROWS - 1;
			rolled = 1'b1;
		end else begin
			row++;
		end
		cursor_lin = row * COLS;
		screen[cursor_lin][15:8] = attr_reg;
		return rolled;
	endfunction

	function automatic rsp_item_t console_predict(req_item_t it);
		rsp_item_t res;
		int unsigned col;
		res = '0;
		case (it.req_type)
		REQ_CHAR: begin
			if (it.char_code == CHAR_NL) begin
				res.scrolled = line_feed();
			end else if (it.char_code == CHAR_TAB) begin
				col = ((cursor_lin % COLS) / 8 + 1) * 8;
				if (col >= COLS) res.scrolled = line_feed();
				else cursor_lin = (cursor_lin / COLS) * COLS + col;
			end else if (it.char_code == CHAR_BS) begin
				if (cursor_lin > 0) cursor_lin--;
				screen[cursor_lin][7:0] = '0;
			end else begin
				screen[cursor_lin] = {attr_reg, it.char_code};
				if (cursor_lin >= NCELLS - 1) begin
					res.scrolled = line_feed();
				end else begin
					cursor_lin++;
					screen[cursor_lin][15:8] = attr_reg;
				end
			end
		end
		REQ_CLEAR: begin
			for (int i = 0; i < NCELLS; i++) screen[i] = '0;
			cursor_lin = 0;
		end
		REQ_READ: begin
			if (it.read_index < NCELLS) {res.cell_attr, res.cell_char} = screen[it.read_index];
		end
		default: ;
		endcase
		res.cursor_col = COL_OUT_W'(cursor_lin % COLS);
		res.cursor_row = ROW_OUT_W'(cursor_lin / COLS);
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic req_item_t random_beat();
		req_item_t it;
		int unsigned r;
		int unsigned back;
		it.req_type = REQ_CHAR;
		it.char_code = 8'($urandom);
		it.read_index = 11'($urandom);
		r = $urandom_range(0, 999);
		if (r < 15) begin
			it.char_code = CHAR_NL;
		end else if (r < 55) begin
			it.char_code = CHAR_TAB;
		end else if (r < 95) begin
			it.char_code = CHAR_BS;
		end else if (r < 105) begin
			it.req_type = REQ_CLEAR;
		end else if (r < 125) begin
			it.req_type = REQ_UNUSED;
		end else if (r < 350) begin
			it.req_type = REQ_READ;
			r = $urandom_range(0, 9);
			back = $urandom_range(0, 2 * COLS);
			if (r < 5) it.read_index = IDX_W'(cursor_lin > back ? cursor_lin - back : 0);
			else if (r < 9) it.read_index = IDX_W'($urandom_range(0, NCELLS - 1));
		end
		return it;
	endfunction

	task automatic send_beat(req_item_t it, logic fixed, rsp_item_t typed, int unsigned gap);
		rsp_item_t want;
		@(negedge clk);
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		want = console_predict(it);
		pending.push_back(fixed ? typed : want);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		while (pending.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ATTR_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic verify_attr(logic [7:0] want);
		logic [31:0] got;
		apb_access(1'b0, '0, got);
		if (got !== {24'b0, want}) begin
			$display("%0t: text_attr read expected %h, got %h", $time, want, got);
			fail_count++;
		end
	endtask

	task automatic set_text_attr(logic [7:0] value);
		logic [31:0] unused;
		apb_access(1'b1, {24'b0, value}, unused);
		attr_reg = value;
		verify_attr(value);
	endtask

	task automatic flag_field(string field, int unsigned want, int unsigned got);
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin : check_results
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending.size() == 0) begin
				$display("%0t: result beat %h with nothing expected", $time, rsp);
				fail_count++;
			end else begin
				want = pending.pop_front();
				if (rsp.cursor_col !== want.cursor_col)
					flag_field("cursor_col", want.cursor_col, rsp.cursor_col);
				if (rsp.cursor_row !== want.cursor_row)
					flag_field("cursor_row", want.cursor_row, rsp.cursor_row);
				if (rsp.cell_char !== want.cell_char)
					flag_field("cell_char", want.cell_char, rsp.cell_char);
				if (rsp.cell_attr !== want.cell_attr)
					flag_field("cell_attr", want.cell_attr, rsp.cell_attr);
				if (rsp.scrolled !== want.scrolled)
					flag_field("scrolled", want.scrolled, rsp.scrolled);
			end
		end
	end

	initial begin
		int unsigned stall_len;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_request = 0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				stall_len = pick_gap();
				if (stall_len > 0) begin
					rsp_stall <= 1'b1;
					repeat (stall_len) @(negedge clk);
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= 1'b0;
					repeat ($urandom_range(0, 20)) @(negedge clk);
				end
			end
		end
	end

	initial begin
		req_item_t  it;
		rsp_item_t  typed;
		logic [7:0] attr_steps [PHASES];
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < NCELLS; i++) screen[i] = '0;
		cursor_lin = (START_ROW < ROWS ? START_ROW : ROWS - 1) * COLS;
		attr_reg = ATTR_RESET;
		attr_steps = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom)};

		// req, ch, idx, reps, fixed, col, row, char, attr, scrolled
		plan = '{
			'{REQ_READ,   8'h00,    11'd0,    8'd1, 1'b1, 7'd0,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'h00,    11'd2047, 8'd1, 1'b1, 7'd0,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'hFF,    11'd1999, 8'd1, 1'b1, 7'd0,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_UNUSED, 8'hFF,    11'd2047, 8'd1, 1'b1, 7'd0,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   8'h41,    11'd0,    8'd1, 1'b1, 7'd1,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'h00,    11'd1520, 8'd1, 1'b1, 7'd1,  5'd19, 8'h41, 8'h03, 1'b0},
			'{REQ_READ,   8'h00,    11'd1521, 8'd1, 1'b1, 7'd1,  5'd19, 8'h00, 8'h03, 1'b0},
			'{REQ_CHAR,   8'h00,    11'd0,    8'd1, 1'b1, 7'd2,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   8'hFF,    11'd2047, 8'd1, 1'b1, 7'd3,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_TAB, 11'd0,    8'd1, 1'b1, 7'd8,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_BS,  11'd0,    8'd1, 1'b1, 7'd7,  5'd19, 8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'h00,    11'd1527, 8'd1, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_NL,  11'd0,    8'd6, 1'b1, 7'd0,  5'd24, 8'h00, 8'h00, 1'b1},
			'{REQ_READ,   8'h00,    11'd1440, 8'd1, 1'b0, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_CLEAR,  8'h00,    11'd0,    8'd1, 1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_BS,  11'd0,    8'd1, 1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'h00,    11'd0,    8'd1, 1'b1, 7'd0,  5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_TAB, 11'd0,    8'd9, 1'b1, 7'd72, 5'd0,  8'h00, 8'h00, 1'b0},
			'{REQ_CHAR,   CHAR_TAB, 11'd0,    8'd1, 1'b1, 7'd0,  5'd1,  8'h00, 8'h00, 1'b0},
			'{REQ_READ,   8'h00,    11'd80,   8'd1, 1'b1, 7'd0,  5'd1,  8'h00, 8'h03, 1'b0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		verify_attr(ATTR_RESET);

		foreach (plan[i]) begin
			for (int n = 0; n < int'(plan[i].reps); n++) begin
				it = '{plan[i].req, plan[i].ch, plan[i].idx};
				typed = '{plan[i].col, plan[i].row, plan[i].cc, plan[i].ca, plan[i].sc};
				send_beat(it, plan[i].fixed && n == int'(plan[i].reps) - 1, typed, pick_gap());
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_text_attr(attr_steps[p]);
			if (p == 2) hold_request = 1;
			repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, '0, p == 2 ? 0 : pick_gap());
			@(negedge clk);
			req_valid <= 1'b0;
			drain();
		end

		if (fail_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dp.sv
hw/rtl/text_console_writer.sv
tb/text_console_writer_tb.sv
